// File: rtl/bvop_pkg.sv
// shared types and constants for the bootp vendor option parser
// no dependencies
package bvop_pkg;

    localparam int EXT_DEPTH_DEF = 256;
    localparam int CNT_W         = 9;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_COOKIE,
        PH_TAG,
        PH_LEN,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_END   = 2'd0,
        ST_CLEAN = 2'd1,
        ST_TRUNC = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    localparam logic REQ_VENDOR   = 1'b0;
    localparam logic REQ_READ     = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    localparam logic [7:0] TAG_PAD    = 8'd0;
    localparam logic [7:0] TAG_MASK   = 8'd1;
    localparam logic [7:0] TAG_ROUTER = 8'd3;
    localparam logic [7:0] TAG_EXT    = 8'd18;
    localparam logic [7:0] TAG_END    = 8'd255;

    localparam logic [1:0] COOKIE_LAST = 2'd3;

    function automatic logic [7:0] cookie_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'd99;
            2'd1:    b = 8'd130;
            2'd2:    b = 8'd83;
            default: b = 8'd99;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/bootp_vendor_option_parser.sv
// bootp vendor area parser: cookie check, option walk, mask/router capture
// extension text buffer; depends on bvop_pkg
// pipeline: two register stages (s1 and output); a result is registered in s1, then in the output stage
// throughput: one transaction per cycle while req_stall is low; state updates at
// acceptance and the extension buffer is a single-port-write, single-port-read memory
// reset: asynchronous, clears parse state and captures; buffer not cleared
module bootp_vendor_option_parser #(
    parameter int EXT_DEPTH = bvop_pkg::EXT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [7:0]  read_index,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        result_kind,
    output logic [1:0]  parse_status,
    output logic        mask_valid,
    output logic [31:0] subnet_mask,
    output logic        gateway_valid,
    output logic [31:0] gateway_addr,
    output logic [7:0]  ext_length,
    output logic [7:0]  read_data
);
    import bvop_pkg::*;

    localparam int AW   = $clog2(EXT_DEPTH);
    localparam int EXTW = $clog2(EXT_DEPTH + 1);

    // parse state
    phase_t          phase_reg, phase_next;
    logic [1:0]      cpos_reg, cpos_next;
    logic [7:0]      tag_reg, tag_next;
    logic [7:0]      left_reg, left_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic [31:0]     shadow_reg, shadow_next;
    logic [31:0]     mask_reg, mask_next;
    logic [31:0]     gw_reg, gw_next;
    logic            mseen_reg, mseen_next;
    logic            gseen_reg, gseen_next;
    logic [EXTW-1:0] extc_reg, extc_next;

    // extension buffer
    logic [7:0]      ext_mem [EXT_DEPTH];
    logic [7:0]      rd_data_reg;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;

    // first stage
    logic            s1_valid_reg;
    logic            s1_kind_reg;
    status_t         s1_status_reg;
    logic            s1_mval_reg;
    logic [31:0]     s1_mask_reg;
    logic            s1_gval_reg;
    logic [31:0]     s1_gw_reg;
    logic [7:0]      s1_elen_reg;
    logic            s1_inrange_reg;

    // output stage
    logic            res_valid_reg;
    logic            out_kind_reg;
    status_t         out_status_reg;
    logic            out_mval_reg;
    logic [31:0]     out_mask_reg;
    logic            out_gval_reg;
    logic [31:0]     out_gw_reg;
    logic [7:0]      out_elen_reg;
    logic [7:0]      out_rdata_reg;

    logic            accept;
    logic            advance;
    logic            emit;
    logic            commit;
    status_t         emit_status;
    logic            has_result;
    logic            in_range;

    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign rd_en     = accept && (req_type == REQ_READ);
    assign in_range  = {1'b0, read_index} < CNT_W'(extc_reg);
    assign has_result = rd_en || (accept && emit);

    always_comb
    begin
        phase_next  = phase_reg;
        cpos_next   = cpos_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        cnt_next    = cnt_reg;
        shadow_next = shadow_reg;
        mask_next   = mask_reg;
        gw_next     = gw_reg;
        mseen_next  = mseen_reg;
        gseen_next  = gseen_reg;
        extc_next   = extc_reg;
        emit        = 1'b0;
        commit      = 1'b0;
        emit_status = ST_END;
        wr_en       = 1'b0;
        wr_addr     = cnt_reg[AW-1:0];
        if (accept && (req_type == REQ_VENDOR))
        begin
            if (first_byte)
            begin
                phase_next  = PH_COOKIE;
                cpos_next   = '0;
                tag_next    = '0;
                left_next   = '0;
                cnt_next    = '0;
                shadow_next = '0;
                mask_next   = '0;
                gw_next     = '0;
                mseen_next  = 1'b0;
                gseen_next  = 1'b0;
                extc_next   = '0;
            end
            unique case (phase_next)
                PH_COOKIE:
                begin
                    if (data_byte != cookie_byte(cpos_next))
                    begin
                        emit        = 1'b1;
                        emit_status = ST_BAD;
                    end
                    else if (cpos_next == COOKIE_LAST)
                    begin
                        cpos_next   = '0;
                        phase_next  = PH_TAG;
                        emit        = last_byte;
                        emit_status = ST_CLEAN;
                    end
                    else
                    begin
                        cpos_next   = cpos_next + 2'd1;
                        emit        = last_byte;
                        emit_status = ST_BAD;
                    end
                end
                PH_TAG:
                begin
                    if (data_byte == TAG_PAD)
                    begin
                        emit        = last_byte;
                        emit_status = ST_CLEAN;
                    end
                    else if (data_byte == TAG_END)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_END;
                    end
                    else
                    begin
                        tag_next    = data_byte;
                        phase_next  = PH_LEN;
                        emit        = last_byte;
                        emit_status = ST_TRUNC;
                    end
                end
                PH_LEN:
                begin
                    left_next   = data_byte;
                    cnt_next    = '0;
                    shadow_next = '0;
                    if (tag_next == TAG_EXT)
                    begin
                        extc_next = '0;
                    end
                    if (data_byte == 8'd0)
                    begin
                        commit      = 1'b1;
                        emit        = last_byte;
                        emit_status = ST_CLEAN;
                    end
                    else
                    begin
                        phase_next  = PH_DATA;
                        emit        = last_byte;
                        emit_status = ST_TRUNC;
                    end
                end
                PH_DATA:
                begin
                    if (cnt_next < 8'd4)
                    begin
                        shadow_next = {shadow_next[23:0], data_byte};
                    end
                    if ((tag_next == TAG_EXT) && ({1'b0, cnt_next} < CNT_W'(EXT_DEPTH)))
                    begin
                        wr_en = 1'b1;
                    end
                    cnt_next  = cnt_next + 8'd1;
                    left_next = left_next - 8'd1;
                    if (left_next == 8'd0)
                    begin
                        commit      = 1'b1;
                        emit        = last_byte;
                        emit_status = ST_CLEAN;
                    end
                    else
                    begin
                        emit        = last_byte;
                        emit_status = ST_TRUNC;
                    end
                end
                default:
                begin
                end
            endcase
            if (commit)
            begin
                if ((tag_next == TAG_MASK) && (cnt_next >= 8'd4))
                begin
                    mask_next  = shadow_next;
                    mseen_next = 1'b1;
                end
                else if ((tag_next == TAG_ROUTER) && (cnt_next >= 8'd4))
                begin
                    gw_next    = shadow_next;
                    gseen_next = 1'b1;
                end
                else if (tag_next == TAG_EXT)
                begin
                    if ({1'b0, cnt_next} < CNT_W'(EXT_DEPTH))
                    begin
                        extc_next = EXTW'(cnt_next);
                    end
                    else
                    begin
                        extc_next = EXTW'(EXT_DEPTH);
                    end
                end
                phase_next = PH_TAG;
            end
            if (emit)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cpos_reg   <= '0;
            tag_reg    <= '0;
            left_reg   <= '0;
            cnt_reg    <= '0;
            shadow_reg <= '0;
            mask_reg   <= '0;
            gw_reg     <= '0;
            mseen_reg  <= 1'b0;
            gseen_reg  <= 1'b0;
            extc_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cpos_reg   <= cpos_next;
            tag_reg    <= tag_next;
            left_reg   <= left_next;
            cnt_reg    <= cnt_next;
            shadow_reg <= shadow_next;
            mask_reg   <= mask_next;
            gw_reg     <= gw_next;
            mseen_reg  <= mseen_next;
            gseen_reg  <= gseen_next;
            extc_reg   <= extc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ext_mem[wr_addr] <= data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= ext_mem[read_index[AW-1:0]];
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= has_result;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (accept && has_result)
        begin
            if (req_type == REQ_READ)
            begin
                s1_kind_reg    <= KIND_READ;
                s1_status_reg  <= ST_END;
                s1_mval_reg    <= 1'b0;
                s1_mask_reg    <= '0;
                s1_gval_reg    <= 1'b0;
                s1_gw_reg      <= '0;
                s1_elen_reg    <= 8'(extc_reg);
                s1_inrange_reg <= in_range;
            end
            else
            begin
                s1_kind_reg    <= KIND_SUMMARY;
                s1_status_reg  <= emit_status;
                s1_mval_reg    <= mseen_next;
                s1_mask_reg    <= mask_next;
                s1_gval_reg    <= gseen_next;
                s1_gw_reg      <= gw_next;
                s1_elen_reg    <= 8'(extc_next);
                s1_inrange_reg <= 1'b0;
            end
        end
        if (advance)
        begin
            out_kind_reg   <= s1_kind_reg;
            out_status_reg <= s1_status_reg;
            out_mval_reg   <= s1_mval_reg;
            out_mask_reg   <= s1_mask_reg;
            out_gval_reg   <= s1_gval_reg;
            out_gw_reg     <= s1_gw_reg;
            out_elen_reg   <= s1_elen_reg;
            out_rdata_reg  <= s1_inrange_reg ? rd_data_reg : 8'd0;
        end
    end

    assign res_valid     = res_valid_reg;
    assign result_kind   = out_kind_reg;
    assign parse_status  = out_status_reg;
    assign mask_valid    = out_mval_reg;
    assign subnet_mask   = out_mask_reg;
    assign gateway_valid = out_gval_reg;
    assign gateway_addr  = out_gw_reg;
    assign ext_length    = out_elen_reg;
    assign read_data     = out_rdata_reg;

endmodule
